>>> rtl/trqs_pkg.sv
// ----------------------------------------------------------------------------
// trqs_pkg
// Types and constants shared by the thread ready queue scheduler modules.
// ----------------------------------------------------------------------------
package trqs_pkg;

    localparam int THREADS = 16;
    localparam int CONDS   = 4;
    localparam int NQUEUES = CONDS + 1;

    localparam int TID_W = $clog2(THREADS);
    localparam int CID_W = $clog2(CONDS);
    localparam int QID_W = $clog2(NQUEUES);
    localparam int VAL_W = 32;

    localparam logic [QID_W-1:0] READY_Q = QID_W'(0);

    typedef enum logic [2:0] {
        CMD_CREATE      = 3'd0,
        CMD_YIELD       = 3'd1,
        CMD_TICK        = 3'd2,
        CMD_EXIT        = 3'd3,
        CMD_JOIN        = 3'd4,
        CMD_COND_INIT   = 3'd5,
        CMD_COND_WAIT   = 3'd6,
        CMD_COND_SIGNAL = 3'd7
    } cmd_t;

    typedef struct packed {
        cmd_t               command;
        logic [TID_W-1:0]   thread_id;
        logic [CID_W-1:0]   cond_id;
        logic [VAL_W-1:0]   exit_value;
    } ev_word_t;

    typedef struct packed {
        logic [TID_W-1:0]   running_id;
        logic               status;
        logic [VAL_W-1:0]   joined_value;
        logic               joined_valid;
        logic [TID_W-1:0]   woken_id;
        logic               woken_valid;
    } res_word_t;

endpackage

>>> rtl/trqs_in_stage.sv
// ----------------------------------------------------------------------------
// trqs_in_stage
// Input register: holds one event word until the update logic takes it.
// ----------------------------------------------------------------------------
module trqs_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                ev_valid,
    output logic                ev_stall,
    input  trqs_pkg::ev_word_t  ev_data,
    input  logic                take,
    output logic                held_valid,
    output trqs_pkg::ev_word_t  held_word
);

    logic               valid_reg;
    logic               valid_next;
    trqs_pkg::ev_word_t word_reg;
    logic               load;

    assign ev_stall   = valid_reg && !take;
    assign load       = ev_valid && !ev_stall;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= ev_data;
        end
    end

endmodule

>>> rtl/trqs_engine.sv
// ----------------------------------------------------------------------------
// trqs_engine
// Scheduler state and the single-pass update of ready and wait queues.
// ----------------------------------------------------------------------------
module trqs_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  trqs_pkg::ev_word_t  word,
    output trqs_pkg::res_word_t result
);

    localparam int TW = trqs_pkg::TID_W;
    localparam int QW = trqs_pkg::QID_W;
    localparam int VW = trqs_pkg::VAL_W;

    logic [TW-1:0] cur_reg,  cur_next;
    logic          cv_reg,   cv_next;
    logic [TW-1:0] head_reg  [trqs_pkg::NQUEUES];
    logic [TW-1:0] head_next [trqs_pkg::NQUEUES];
    logic [TW-1:0] tail_reg  [trqs_pkg::NQUEUES];
    logic [TW-1:0] tail_next [trqs_pkg::NQUEUES];
    logic          ne_reg    [trqs_pkg::NQUEUES];
    logic          ne_next   [trqs_pkg::NQUEUES];
    logic [TW-1:0] link_reg  [trqs_pkg::THREADS];
    logic          fin_reg   [trqs_pkg::THREADS];
    logic [TW-1:0] wid_reg   [trqs_pkg::THREADS];
    logic          wv_reg    [trqs_pkg::THREADS];
    logic [VW-1:0] saved_reg [trqs_pkg::THREADS];

    logic          link_we;
    logic [TW-1:0] link_waddr;
    logic [TW-1:0] link_wdata;
    logic          fin_we;
    logic [TW-1:0] fin_addr;
    logic          fin_data;
    logic          wv_we;
    logic [TW-1:0] wv_addr;
    logic          wv_data;
    logic          wid_we;
    logic [TW-1:0] wid_addr;
    logic          sv_we;
    logic [TW-1:0] sv_addr;

    logic [QW-1:0] cq;
    logic [TW-1:0] tid;

    assign cq  = QW'(word.cond_id) + QW'(1);
    assign tid = word.thread_id;

    always_comb
    begin
        logic          pre_pop;
        logic [TW-1:0] pre_t;
        logic          push_en;
        logic [QW-1:0] push_q;
        logic [TW-1:0] push_t;
        logic          dispatch;
        logic [TW-1:0] h;
        logic [TW-1:0] lnk;
        logic [VW-1:0] jval;
        logic          jvalid;
        logic [TW-1:0] wk_id;
        logic          wk_valid;

        pre_pop  = 1'b0;
        pre_t    = '0;
        push_en  = 1'b0;
        push_q   = trqs_pkg::READY_Q;
        push_t   = '0;
        dispatch = 1'b0;
        h        = '0;
        lnk      = '0;
        jval     = '0;
        jvalid   = 1'b0;
        wk_id    = '0;
        wk_valid = 1'b0;

        cur_next  = cur_reg;
        cv_next   = cv_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        ne_next   = ne_reg;

        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        fin_we     = 1'b0;
        fin_addr   = tid;
        fin_data   = 1'b0;
        wv_we      = 1'b0;
        wv_addr    = tid;
        wv_data    = 1'b0;
        wid_we     = 1'b0;
        wid_addr   = tid;
        sv_we      = 1'b0;
        sv_addr    = cur_reg;

        unique case (word.command)
            trqs_pkg::CMD_CREATE:
            begin
                fin_we  = 1'b1;
                wv_we   = 1'b1;
                push_en = 1'b1;
                push_t  = tid;
            end
            trqs_pkg::CMD_YIELD, trqs_pkg::CMD_TICK:
            begin
                push_en  = cv_reg;
                push_t   = cur_reg;
                dispatch = 1'b1;
            end
            trqs_pkg::CMD_EXIT:
            begin
                if (cv_reg)
                begin
                    sv_we    = 1'b1;
                    fin_we   = 1'b1;
                    fin_addr = cur_reg;
                    fin_data = 1'b1;
                    if (wv_reg[cur_reg])
                    begin
                        wv_we    = 1'b1;
                        wv_addr  = cur_reg;
                        wk_id    = wid_reg[cur_reg];
                        wk_valid = 1'b1;
                        push_en  = 1'b1;
                        push_t   = wid_reg[cur_reg];
                    end
                    dispatch = 1'b1;
                end
            end
            trqs_pkg::CMD_JOIN:
            begin
                if (cv_reg)
                begin
                    if (fin_reg[tid])
                    begin
                        jval   = saved_reg[tid];
                        jvalid = (saved_reg[tid] != '0);
                    end
                    else
                    begin
                        wid_we   = 1'b1;
                        wv_we    = 1'b1;
                        wv_data  = 1'b1;
                        dispatch = 1'b1;
                    end
                end
            end
            trqs_pkg::CMD_COND_INIT:
            begin
                ne_next[cq] = 1'b0;
            end
            trqs_pkg::CMD_COND_WAIT:
            begin
                if (cv_reg)
                begin
                    push_en  = 1'b1;
                    push_q   = cq;
                    push_t   = cur_reg;
                    dispatch = 1'b1;
                end
            end
            trqs_pkg::CMD_COND_SIGNAL:
            begin
                pre_pop = 1'b1;
            end
        endcase

        // signal: take the wait head first
        if (pre_pop && ne_next[cq])
        begin
            pre_t  = head_next[cq];
            if (pre_t == tail_next[cq])
            begin
                ne_next[cq] = 1'b0;
            end
            else
            begin
                head_next[cq] = link_reg[pre_t];
            end
            push_en  = 1'b1;
            push_t   = pre_t;
            wk_id    = pre_t;
            wk_valid = 1'b1;
        end

        // append at tail
        if (push_en)
        begin
            if (ne_next[push_q])
            begin
                link_we    = 1'b1;
                link_waddr = tail_next[push_q];
                link_wdata = push_t;
            end
            else
            begin
                head_next[push_q] = push_t;
                ne_next[push_q]   = 1'b1;
            end
            tail_next[push_q] = push_t;
        end

        // ready head runs next
        if (dispatch)
        begin
            if (ne_next[trqs_pkg::READY_Q])
            begin
                h        = head_next[trqs_pkg::READY_Q];
                cur_next = h;
                cv_next  = 1'b1;
                if (link_we && (link_waddr == h))
                begin
                    lnk = link_wdata;
                end
                else
                begin
                    lnk = link_reg[h];
                end
                if (h == tail_next[trqs_pkg::READY_Q])
                begin
                    ne_next[trqs_pkg::READY_Q] = 1'b0;
                end
                else
                begin
                    head_next[trqs_pkg::READY_Q] = lnk;
                end
            end
            else
            begin
                cur_next = '0;
                cv_next  = 1'b0;
            end
        end

        result.running_id   = cv_next ? cur_next : '0;
        result.status       = !cv_next;
        result.joined_value = jval;
        result.joined_valid = jvalid;
        result.woken_id     = wk_valid ? wk_id : '0;
        result.woken_valid  = wk_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg <= '0;
            cv_reg  <= 1'b1;
            for (int q = 0; q < trqs_pkg::NQUEUES; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                ne_reg[q]   <= 1'b0;
            end
            for (int t = 0; t < trqs_pkg::THREADS; t++)
            begin
                fin_reg[t] <= 1'b0;
                wv_reg[t]  <= 1'b0;
            end
        end
        else if (go)
        begin
            cur_reg  <= cur_next;
            cv_reg   <= cv_next;
            head_reg <= head_next;
            tail_reg <= tail_next;
            ne_reg   <= ne_next;
            if (fin_we)
            begin
                fin_reg[fin_addr] <= fin_data;
            end
            if (wv_we)
            begin
                wv_reg[wv_addr] <= wv_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (link_we)
            begin
                link_reg[link_waddr] <= link_wdata;
            end
            if (wid_we)
            begin
                wid_reg[wid_addr] <= cur_reg;
            end
            if (sv_we)
            begin
                saved_reg[sv_addr] <= word.exit_value;
            end
        end
    end

endmodule

>>> rtl/trqs_out_stage.sv
// ----------------------------------------------------------------------------
// trqs_out_stage
// Result register: holds one result word until the receiver takes it.
// ----------------------------------------------------------------------------
module trqs_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    input  trqs_pkg::res_word_t  src_word,
    output logic                 take,
    output logic                 res_valid,
    input  logic                 res_stall,
    output trqs_pkg::res_word_t  res_data
);

    logic                valid_reg;
    logic                valid_next;
    trqs_pkg::res_word_t word_reg;

    assign take      = src_valid && (!valid_reg || !res_stall);
    assign res_valid = valid_reg;
    assign res_data  = word_reg;

    always_comb
    begin
        priority if (take)
        begin
            valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            word_reg <= src_word;
        end
    end

endmodule

>>> rtl/thread_ready_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// thread_ready_queue_scheduler_core
// Round robin scheduler for 16 threads with a ready queue and 4 wait queues.
// ----------------------------------------------------------------------------
// Each event word is captured in an input register, applied to the queue
// state (head, tail and link registers) and its result word is held in an
// output register. One word is taken per clock while the receiver does not
// stall; the result is registered in the output stage as the word leaves the
// input register. Thread 0 runs after reset and no start-up sweep is needed:
// the link, joiner and saved-value tables are only read after being written
// in correct use.
module thread_ready_queue_scheduler_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 ev_valid,
    output logic                 ev_stall,
    input  trqs_pkg::ev_word_t   ev_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output trqs_pkg::res_word_t  res_data
);

    logic                held_valid;
    trqs_pkg::ev_word_t  held_word;
    trqs_pkg::res_word_t result;
    logic                take;

    trqs_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .ev_valid   (ev_valid),
        .ev_stall   (ev_stall),
        .ev_data    (ev_data),
        .take       (take),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    trqs_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (take),
        .word   (held_word),
        .result (result)
    );

    trqs_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (held_valid),
        .src_word  (result),
        .take      (take),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

>>> verif/tb_thread_ready_queue_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_thread_ready_queue_scheduler_core
// Self-checking bench for the round robin thread scheduler core. A short table
// of directed event words walks reset, idle, join, wakeup and condition corner
// cases. About six hundred random event words follow. Most of them are sensible
// thread traffic, and the rest is misuse. A predictor of its own tracks run,
// ready, wait and joiner state. Every result word is checked field by field
// against it or a pinned row. Random stall and idle phases run on both channels.
// ----------------------------------------------------------------------------
module tb_thread_ready_queue_scheduler_core;

    localparam int THREADS          = trqs_pkg::THREADS;
    localparam int CONDS            = trqs_pkg::CONDS;
    localparam int NQUEUES          = trqs_pkg::NQUEUES;
    localparam int TID_W            = trqs_pkg::TID_W;
    localparam int CID_W            = trqs_pkg::CID_W;
    localparam int VAL_W            = trqs_pkg::VAL_W;
    localparam int READY            = int'(trqs_pkg::READY_Q);
    localparam int QUIET_LIMIT      = 5000;
    localparam int RANDOM_PER_PHASE = 150;
    localparam int PLAN_ROWS        = 25;

    typedef struct packed {
        trqs_pkg::cmd_t   cmd;
        logic [TID_W-1:0] tid;
        logic [CID_W-1:0] cid;
        logic [VAL_W-1:0] val;
        logic             pin;
        logic [TID_W-1:0] run;
        logic             idle;
        logic [VAL_W-1:0] jval;
        logic             jok;
        logic [TID_W-1:0] wake;
        logic             wok;
    } plan_row_t;

    // pin set: result typed in, otherwise taken from the predictor
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{trqs_pkg::CMD_YIELD,       4'd0,  2'd0, 32'h0,         1'b1,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_CREATE,      4'd15, 2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_CREATE,      4'd1,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_TICK,        4'd0,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_EXIT,        4'd0,  2'd0, 32'hFFFF_FFFF, 1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_JOIN,        4'd15, 2'd0, 32'h0,         1'b1,
          4'd1, 1'b0, 32'hFFFF_FFFF, 1'b1, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_WAIT,   4'd0,  2'd3, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_WAIT,   4'd0,  2'd3, 32'h0,         1'b1,
          4'd0, 1'b1, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_EXIT,        4'd0,  2'd0, 32'h1234_5678, 1'b1,
          4'd0, 1'b1, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_JOIN,        4'd0,  2'd0, 32'h0,         1'b1,
          4'd0, 1'b1, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_WAIT,   4'd0,  2'd0, 32'h0,         1'b1,
          4'd0, 1'b1, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_YIELD,       4'd0,  2'd0, 32'h0,         1'b1,
          4'd0, 1'b1, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_SIGNAL, 4'd0,  2'd3, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_TICK,        4'd0,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_SIGNAL, 4'd0,  2'd2, 32'h0,         1'b1,
          4'd1, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_INIT,   4'd0,  2'd3, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_COND_SIGNAL, 4'd0,  2'd3, 32'h0,         1'b1,
          4'd1, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_CREATE,      4'd2,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_JOIN,        4'd2,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_EXIT,        4'd0,  2'd0, 32'h0,         1'b1,
          4'd1, 1'b0, 32'h0, 1'b0, 4'd1, 1'b1},
        '{trqs_pkg::CMD_JOIN,        4'd2,  2'd0, 32'h0,         1'b1,
          4'd1, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_JOIN,        4'd1,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_CREATE,      4'd7,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_TICK,        4'd0,  2'd0, 32'h0,         1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0},
        '{trqs_pkg::CMD_EXIT,        4'd0,  2'd0, 32'hA5A5_5A5A, 1'b0,
          4'd0, 1'b0, 32'h0, 1'b0, 4'd0, 1'b0}
    };

    logic                clk;
    logic                rst_n;
    logic                ev_valid;
    logic                ev_stall;
    trqs_pkg::ev_word_t  ev_data;
    logic                res_valid;
    logic                res_stall = 1'b0;
    trqs_pkg::res_word_t res_data;

    logic                pin_valid;
    trqs_pkg::res_word_t pin_word;
    trqs_pkg::res_word_t expected_results [$];

    // scheduler state as the predictor sees it
    logic [TID_W-1:0] run_tid;
    logic             run_ok;
    logic [TID_W-1:0] next_tid [THREADS];
    logic             next_set [THREADS];
    logic [TID_W-1:0] q_head [NQUEUES];
    logic [TID_W-1:0] q_tail [NQUEUES];
    logic             q_nonempty [NQUEUES];
    logic             done_flag [THREADS];
    logic [TID_W-1:0] joiner [THREADS];
    logic             joiner_ok [THREADS];
    logic [VAL_W-1:0] exit_val [THREADS];

    int errors = 0;
    int events_sent = 0;
    int words_checked = 0;
    int woken_seen = 0;
    int joined_seen = 0;
    int idle_seen = 0;
    int quiet_cycles = 0;
    int send_gap_pct = 0;
    int recv_stall_pct = 0;

    thread_ready_queue_scheduler_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (ev_valid),
        .ev_stall  (ev_stall),
        .ev_data   (ev_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void sched_reset();
        run_tid = '0;
        run_ok  = 1'b1;
        for (int t = 0; t < THREADS; t++)
        begin
            next_tid[t]  = '0;
            next_set[t]  = 1'b0;
            done_flag[t] = 1'b0;
            joiner[t]    = '0;
            joiner_ok[t] = 1'b0;
            exit_val[t]  = '0;
        end
        for (int q = 0; q < NQUEUES; q++)
        begin
            q_head[q]     = '0;
            q_tail[q]     = '0;
            q_nonempty[q] = 1'b0;
        end
    endfunction

    function automatic void list_push(input int q, input logic [TID_W-1:0] t);
        if (q_nonempty[q])
        begin
            next_tid[q_tail[q]] = t;
            next_set[q_tail[q]] = 1'b1;
        end
        else
        begin
            q_head[q]     = t;
            q_nonempty[q] = 1'b1;
        end
        q_tail[q] = t;
    endfunction

    function automatic logic list_pop(input int q, output logic [TID_W-1:0] t);
        t = q_head[q];
        if (!q_nonempty[q])
            return 1'b0;
        if (t == q_tail[q])
            q_nonempty[q] = 1'b0;
        else
            q_head[q] = next_tid[t];
        return 1'b1;
    endfunction

    function automatic void dispatch_next();
        logic [TID_W-1:0] t;
        if (list_pop(READY, t))
        begin
            run_tid = t;
            run_ok  = 1'b1;
        end
        else
        begin
            run_tid = '0;
            run_ok  = 1'b0;
        end
    endfunction

    function automatic trqs_pkg::res_word_t sched_predict(input trqs_pkg::ev_word_t e);
        trqs_pkg::res_word_t r;
        logic [TID_W-1:0]    w;
        int                  cq;
        r  = '0;
        cq = int'(e.cond_id) + 1;
        case (e.command)
            trqs_pkg::CMD_CREATE:
            begin
                done_flag[e.thread_id] = 1'b0;
                joiner_ok[e.thread_id] = 1'b0;
                list_push(READY, e.thread_id);
            end
            trqs_pkg::CMD_YIELD, trqs_pkg::CMD_TICK:
            begin
                if (run_ok)
                    list_push(READY, run_tid);
                dispatch_next();
            end
            trqs_pkg::CMD_EXIT:
            begin
                if (run_ok)
                begin
                    exit_val[run_tid]  = e.exit_value;
                    done_flag[run_tid] = 1'b1;
                    if (joiner_ok[run_tid])
                    begin
                        joiner_ok[run_tid] = 1'b0;
                        r.woken_id         = joiner[run_tid];
                        r.woken_valid      = 1'b1;
                        list_push(READY, r.woken_id);
                    end
                    dispatch_next();
                end
            end
            trqs_pkg::CMD_JOIN:
            begin
                if (run_ok)
                begin
                    if (done_flag[e.thread_id])
                    begin
                        r.joined_value = exit_val[e.thread_id];
                        r.joined_valid = (exit_val[e.thread_id] != '0);
                    end
                    else
                    begin
                        joiner[e.thread_id]    = run_tid;
                        joiner_ok[e.thread_id] = 1'b1;
                        dispatch_next();
                    end
                end
            end
            trqs_pkg::CMD_COND_INIT:
                q_nonempty[cq] = 1'b0;
            trqs_pkg::CMD_COND_WAIT:
            begin
                if (run_ok)
                begin
                    list_push(cq, run_tid);
                    dispatch_next();
                end
            end
            trqs_pkg::CMD_COND_SIGNAL:
            begin
                if (list_pop(cq, w))
                begin
                    list_push(READY, w);
                    r.woken_id    = w;
                    r.woken_valid = 1'b1;
                end
            end
        endcase
        r.running_id = run_ok ? run_tid : '0;
        r.status     = !run_ok;
        return r;
    endfunction

    // true when the word would make a pop follow a link entry never written
    function automatic logic stale_link_read(input trqs_pkg::ev_word_t e);
        int               cq;
        int               pq;
        logic [TID_W-1:0] pt;
        logic [TID_W-1:0] hq;
        logic [TID_W-1:0] tail_now;
        logic [TID_W-1:0] wrote;
        logic             pushing;
        logic             wrote_ok;
        logic             ne_now;
        cq       = int'(e.cond_id) + 1;
        pq       = READY;
        pt       = run_tid;
        pushing  = 1'b0;
        wrote_ok = 1'b0;
        wrote    = '0;
        case (e.command)
            trqs_pkg::CMD_CREATE, trqs_pkg::CMD_COND_INIT:
                return 1'b0;
            trqs_pkg::CMD_COND_SIGNAL:
            begin
                hq = q_head[cq];
                return q_nonempty[cq] && hq != q_tail[cq] && !next_set[hq];
            end
            trqs_pkg::CMD_YIELD, trqs_pkg::CMD_TICK:
                pushing = run_ok;
            trqs_pkg::CMD_EXIT:
            begin
                if (!run_ok)
                    return 1'b0;
                pushing = joiner_ok[run_tid];
                pt      = joiner[run_tid];
            end
            trqs_pkg::CMD_JOIN:
            begin
                if (!run_ok || done_flag[e.thread_id])
                    return 1'b0;
            end
            trqs_pkg::CMD_COND_WAIT:
            begin
                if (!run_ok)
                    return 1'b0;
                pushing = 1'b1;
                pq      = cq;
            end
        endcase
        tail_now = q_tail[READY];
        ne_now   = q_nonempty[READY];
        if (pushing)
        begin
            if (q_nonempty[pq])
            begin
                wrote_ok = 1'b1;
                wrote    = q_tail[pq];
            end
            if (pq == READY)
            begin
                if (!ne_now)
                    return 1'b0;
                tail_now = pt;
            end
        end
        hq = q_head[READY];
        return ne_now && hq != tail_now && !next_set[hq] && !(wrote_ok && wrote == hq);
    endfunction

    function automatic logic thread_in_use(input logic [TID_W-1:0] t);
        logic [TID_W-1:0] x;
        if (run_ok && run_tid == t)
            return 1'b1;
        for (int i = 0; i < THREADS; i++)
            if (joiner_ok[i] && joiner[i] == t)
                return 1'b1;
        for (int q = 0; q < NQUEUES; q++)
        begin
            if (q_nonempty[q])
            begin
                x = q_head[q];
                for (int k = 0; k < THREADS; k++)
                begin
                    if (x == t)
                        return 1'b1;
                    if (x == q_tail[q])
                        break;
                    x = next_tid[x];
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic trqs_pkg::ev_word_t pick_event();
        trqs_pkg::ev_word_t e;
        int                 roll;
        int                 start;
        logic [TID_W-1:0]   cand;
        for (int attempt = 0; attempt < 32; attempt++)
        begin
            e.thread_id = TID_W'($urandom_range(THREADS - 1));
            e.cond_id   = CID_W'($urandom_range(CONDS - 1));
            roll = $urandom_range(7);
            if (roll == 0)
                e.exit_value = '0;
            else if (roll == 1)
                e.exit_value = '1;
            else
                e.exit_value = $urandom();
            roll = $urandom_range(99);
            // when idle, lean toward words that bring a thread back
            if (!run_ok && roll < 50)
                roll = (roll < 25) ? 0 : 35;
            if (roll < 18)
                e.command = trqs_pkg::CMD_CREATE;
            else if (roll < 30)
                e.command = trqs_pkg::CMD_YIELD;
            else if (roll < 42)
                e.command = trqs_pkg::CMD_TICK;
            else if (roll < 56)
                e.command = trqs_pkg::CMD_EXIT;
            else if (roll < 68)
                e.command = trqs_pkg::CMD_JOIN;
            else if (roll < 73)
                e.command = trqs_pkg::CMD_COND_INIT;
            else if (roll < 86)
                e.command = trqs_pkg::CMD_COND_WAIT;
            else
                e.command = trqs_pkg::CMD_COND_SIGNAL;
            if (e.command == trqs_pkg::CMD_CREATE && $urandom_range(9) != 0)
            begin
                start = $urandom_range(THREADS - 1);
                for (int k = 0; k < THREADS; k++)
                begin
                    cand = TID_W'((start + k) % THREADS);
                    if (!thread_in_use(cand))
                    begin
                        e.thread_id = cand;
                        break;
                    end
                end
            end
            if (!stale_link_read(e))
                return e;
        end
        e.command = trqs_pkg::CMD_COND_INIT;
        return e;
    endfunction

    task automatic send_word(input trqs_pkg::ev_word_t e, input logic pinned,
                             input trqs_pkg::res_word_t want);
        while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct)
        begin
            ev_valid <= 1'b0;
            @(negedge clk);
        end
        ev_valid  <= 1'b1;
        ev_data   <= e;
        pin_valid <= pinned;
        pin_word  <= want;
        @(posedge clk);
        while (ev_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        ev_valid <= 1'b0;
        @(negedge clk);
        while (expected_results.size() != 0)
            @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        res_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : result_check
        trqs_pkg::res_word_t want;
        trqs_pkg::res_word_t got;
        if (rst_n)
        begin
            if (res_valid && !res_stall)
            begin
                got = res_data;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result word with nothing expected: %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    words_checked++;
                    if (got.woken_valid === 1'b1)
                        woken_seen++;
                    if (got.joined_valid === 1'b1)
                        joined_seen++;
                    if (got.status === 1'b1)
                        idle_seen++;
                    if (got.running_id !== want.running_id || got.status !== want.status
                        || got.joined_value !== want.joined_value
                        || got.joined_valid !== want.joined_valid
                        || got.woken_id !== want.woken_id
                        || got.woken_valid !== want.woken_valid)
                    begin
                        $display("%0t: expected run %0d idle %0d join %h/%0d wake %0d/%0d",
                                 $time, want.running_id, want.status, want.joined_value,
                                 want.joined_valid, want.woken_id, want.woken_valid);
                        $display("%0t: actual   run %0d idle %0d join %h/%0d wake %0d/%0d",
                                 $time, got.running_id, got.status, got.joined_value,
                                 got.joined_valid, got.woken_id, got.woken_valid);
                        errors++;
                    end
                end
            end
            if (ev_valid && !ev_stall)
            begin
                want = sched_predict(ev_data);
                if (pin_valid)
                    want = pin_word;
                expected_results.push_back(want);
                events_sent++;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (ev_valid && !ev_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        trqs_pkg::ev_word_t  e;
        trqs_pkg::res_word_t want;
        rst_n     = 1'b0;
        ev_valid  = 1'b0;
        ev_data   = '0;
        pin_valid = 1'b0;
        pin_word  = '0;
        sched_reset();
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            e    = '{PLAN[i].cmd, PLAN[i].tid, PLAN[i].cid, PLAN[i].val};
            want = '{PLAN[i].run, PLAN[i].idle, PLAN[i].jval, PLAN[i].jok,
                     PLAN[i].wake, PLAN[i].wok};
            send_word(e, PLAN[i].pin, want);
        end
        wait_drained();

        // phases: no idling, sender idle, receiver stalling, both
        for (int phase = 0; phase < 4; phase++)
        begin
            send_gap_pct   = (phase == 1) ? 80 : (phase == 3) ? 33 : 0;
            recv_stall_pct = (phase == 2) ? 80 : (phase == 3) ? 33 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_word(pick_event(), 1'b0, '0);
            wait_drained();
        end
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        repeat (6) @(negedge clk);

        $display("scheduler run: %0d event words in, %0d result words checked",
                 events_sent, words_checked);
        $display("  seen: %0d wakeups, %0d joins with a value, %0d idle results",
                 woken_seen, joined_seen, idle_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
